/* rtl/core/swrm_pkg.sv */
// shared types and constants of the sliding window rate meter
package swrm_pkg;

    // fixed field widths
    localparam int SIZE_BITS      = 32;
    localparam int CFG_BITS       = 32;
    localparam int CFG_ADDR_BITS  = 1;
    localparam int SIZE_RATE_BITS = 56;
    localparam int TASK_RATE_BITS = 24;
    localparam int DIV_BITS       = 64;

    localparam logic [DIV_BITS-1:0] MS_PER_S = DIV_BITS'(1000);

    localparam logic [CFG_BITS-1:0] PERIOD_RESET = CFG_BITS'(1000);
    localparam logic [CFG_BITS-1:0] POWER_RESET  = CFG_BITS'(1);

    localparam logic [SIZE_RATE_BITS-1:0] SIZE_RATE_MAX = '1;
    localparam logic [TASK_RATE_BITS-1:0] TASK_RATE_MAX = '1;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_PERIOD_MS   = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_EVENT_BATCH = 1'd1;

    // action codes
    localparam logic ACT_ADD     = 1'b0;
    localparam logic ACT_CLEANUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    // control of one cell of the task chain
    typedef struct packed {
        logic pop;   // take the neighbor's entry
        logic load;  // take the new entry
    } t_cell_ctrl;

endpackage

/* rtl/core/swrm_cell.sv */
// one cell of the task chain: holds a task's time and size
module swrm_cell #(
    parameter int TIME_BITS = 48
) (
    input  logic                           i_clk,
    input  swrm_pkg::t_cell_ctrl           i_ctrl,
    input  logic [TIME_BITS-1:0]           i_new_time,
    input  logic [swrm_pkg::SIZE_BITS-1:0] i_new_weight,
    input  logic [TIME_BITS-1:0]           i_next_time,
    input  logic [swrm_pkg::SIZE_BITS-1:0] i_next_weight,
    output logic [TIME_BITS-1:0]           o_time,
    output logic [swrm_pkg::SIZE_BITS-1:0] o_weight
);

    logic [TIME_BITS-1:0]           r_time;
    logic [swrm_pkg::SIZE_BITS-1:0] r_weight;
    logic [TIME_BITS-1:0]           n_time;
    logic [swrm_pkg::SIZE_BITS-1:0] n_weight;

    always_comb begin
        n_time   = r_time;
        n_weight = r_weight;
        if (i_ctrl.pop) begin
            n_time   = i_next_time;
            n_weight = i_next_weight;
        end else if (i_ctrl.load) begin
            n_time   = i_new_time;
            n_weight = i_new_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time   <= n_time;
        r_weight <= n_weight;
    end

    assign o_time   = r_time;
    assign o_weight = r_weight;

endmodule

/* rtl/core/swrm_div.sv */
// restoring divider, one quotient bit per cycle
module swrm_div #(
    parameter int NUM_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [NUM_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_quo;
    logic [NUM_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [NUM_BITS:0]   w_rem_sh;
    logic [NUM_BITS:0]   w_diff;

    assign w_rem_sh = {r_rem, r_quo[NUM_BITS-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            // trial subtract, keep the shifted remainder on borrow
            if (!w_diff[NUM_BITS]) begin
                r_rem <= w_diff[NUM_BITS-1:0];
                r_quo <= {r_quo[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[NUM_BITS-1:0];
                r_quo <= {r_quo[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/core/sliding_window_rate_meter_core.sv */
// top level of the sliding window rate meter
//
// usage
//   input stream: one transfer per item, tuser is the action (add a completed
//   task or clean up expired tasks), tdata holds the time in ms and the size.
//   output stream: one transfer per item with the held size and task rates
//   (unsigned fixed point, FRAC_BITS fraction bits), the tasks held, and the
//   rejected flag in tuser. i_cfg_wr_en writes period_ms (index 0) or the
//   event batch (index 1, adds or removals between re-assessments and also a
//   rate divisor); write only while no item is in flight.
// sequencing
//   items are handled one at a time. an add, or a cleanup of an empty window,
//   goes from the idle step straight to the output step; any other cleanup
//   first pops the expired tasks from the cell chain head in turn.
//   a re-assessment adds a start step and a run of the serial divider
//   before the output step. the next input transfer can be taken as soon
//   as the result is registered.
// reset: synchronous active low; window empty, counters and rates zero,
//   period_ms 1000 and event batch 1.
// stalls: the result sits in an output register; the next item is taken
//   while it waits and is held in its final step until the register frees up.
module sliding_window_rate_meter_core #(
    parameter int FIFO_DEPTH = 64,
    parameter int TIME_BITS  = 48,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: now_ms [TIME_BITS-1:0], task_size, zero padding
    input  logic [((TIME_BITS+32+7)/8)*8-1:0]     i_s_axis_tdata,
    // tuser: action
    input  logic                                 i_s_axis_tuser,
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: rate_in_size, rate_in_tasks, tasks_held, zero padding
    output logic [((80+$clog2(FIFO_DEPTH+1)+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser: add_rejected
    output logic                                 o_m_axis_tuser,
    // configuration write port
    input  logic                                 i_cfg_wr_en,
    input  logic [swrm_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [swrm_pkg::CFG_BITS-1:0]        i_cfg_wr_data
);

    localparam int CNT_BITS  = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_BITS  = swrm_pkg::SIZE_BITS + $clog2(FIFO_DEPTH);
    localparam int OUT_BITS  = ((80 + CNT_BITS + 7) / 8) * 8;
    localparam int SR_BITS   = swrm_pkg::SIZE_RATE_BITS;
    localparam int TR_BITS   = swrm_pkg::TASK_RATE_BITS;
    localparam int DIV_BITS  = swrm_pkg::DIV_BITS;
    localparam int SZ_BITS   = swrm_pkg::SIZE_BITS;
    localparam logic [DIV_BITS-1:0] NUM_LIMIT = {DIV_BITS{1'b1}} >> FRAC_BITS;

    // input fields
    logic [TIME_BITS-1:0] w_now;
    logic [SZ_BITS-1:0]   w_size;
    logic                 w_action;

    assign w_now    = i_s_axis_tdata[TIME_BITS-1:0];
    assign w_size   = i_s_axis_tdata[TIME_BITS+SZ_BITS-1:TIME_BITS];
    assign w_action = i_s_axis_tuser;

    // configuration registers
    logic [swrm_pkg::CFG_BITS-1:0] r_period;
    logic [swrm_pkg::CFG_BITS-1:0] r_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= swrm_pkg::PERIOD_RESET;
            r_power  <= swrm_pkg::POWER_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                swrm_pkg::REG_PERIOD_MS:   r_period <= i_cfg_wr_data;
                swrm_pkg::REG_EVENT_BATCH: r_power  <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // state
    swrm_pkg::t_state       r_state,  n_state;
    logic [CNT_BITS-1:0]    r_count,  n_count;
    logic [SUM_BITS-1:0]    r_sum,    n_sum;
    logic [31:0]            r_adds,   n_adds;
    logic [31:0]            r_removals, n_removals;
    logic [TIME_BITS-1:0]   r_board,  n_board;
    logic                   r_rejected, n_rejected;
    logic [SR_BITS-1:0]     r_size_rate, n_size_rate;
    logic [TR_BITS-1:0]     r_task_rate, n_task_rate;
    logic                   r_sat_size, n_sat_size;
    logic                   r_sat_task, n_sat_task;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]    r_out_data, n_out_data;
    logic                   r_out_user, n_out_user;

    // cell chain, cell 0 is the oldest task
    logic [TIME_BITS-1:0]   w_time   [FIFO_DEPTH];
    logic [SZ_BITS-1:0]     w_weight [FIFO_DEPTH];
    swrm_pkg::t_cell_ctrl   w_ctrl   [FIFO_DEPTH];
    logic                   w_pop;
    logic                   w_load;

    genvar gi;
    generate
        for (gi = 0; gi < FIFO_DEPTH; gi++) begin : g_cell
            logic [TIME_BITS-1:0] w_next_time;
            logic [SZ_BITS-1:0]   w_next_weight;

            // last cell just keeps its (now stale) entry on a pop
            if (gi == FIFO_DEPTH - 1) begin : g_last
                assign w_next_time   = w_time[gi];
                assign w_next_weight = w_weight[gi];
            end else begin : g_mid
                assign w_next_time   = w_time[gi+1];
                assign w_next_weight = w_weight[gi+1];
            end

            assign w_ctrl[gi].pop  = w_pop;
            assign w_ctrl[gi].load = w_load && (r_count == CNT_BITS'(gi));

            swrm_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl[gi]),
                .i_new_time    (w_now),
                .i_new_weight  (w_size),
                .i_next_time   (w_next_time),
                .i_next_weight (w_next_weight),
                .o_time        (w_time[gi]),
                .o_weight      (w_weight[gi])
            );
        end
    endgenerate

    // assessment operands: value * 1000 * 2^FRAC_BITS over period * power
    logic [DIV_BITS-1:0] w_den;
    logic [DIV_BITS-1:0] w_prod_size;
    logic [DIV_BITS-1:0] w_prod_task;
    logic [DIV_BITS-1:0] w_num_size;
    logic [DIV_BITS-1:0] w_num_task;
    logic                w_zero_cfg;
    logic                w_div_start;
    logic                w_done_size;
    logic                w_done_task;
    logic [DIV_BITS-1:0] w_quo_size;
    logic [DIV_BITS-1:0] w_quo_task;

    assign w_den       = DIV_BITS'(r_period) * DIV_BITS'(r_power);
    assign w_prod_size = DIV_BITS'(r_sum) * swrm_pkg::MS_PER_S;
    assign w_prod_task = DIV_BITS'(r_count) * swrm_pkg::MS_PER_S;
    assign w_num_size  = w_prod_size << FRAC_BITS;
    assign w_num_task  = w_prod_task << FRAC_BITS;
    assign w_zero_cfg  = (r_period == '0) || (r_power == '0);

    // both rates share the divisor and run side by side
    swrm_div #(
        .NUM_BITS (DIV_BITS)
    ) u_div_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_size),
        .i_den   (w_den),
        .o_done  (w_done_size),
        .o_quo   (w_quo_size)
    );

    swrm_div #(
        .NUM_BITS (DIV_BITS)
    ) u_div_task (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_task),
        .i_den   (w_den),
        .o_done  (w_done_task),
        .o_quo   (w_quo_task)
    );

    // head entry and cleanup boundary
    logic                 w_head_old;
    logic [31:0]          w_adds_inc;
    logic [TIME_BITS-1:0] w_period_ext;

    assign w_period_ext = TIME_BITS'(r_period);
    assign w_head_old   = (r_count != '0) && (w_time[0] < r_board);
    assign w_adds_inc   = r_adds + 32'd1;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sum        = r_sum;
        n_adds       = r_adds;
        n_removals   = r_removals;
        n_board      = r_board;
        n_rejected   = r_rejected;
        n_size_rate  = r_size_rate;
        n_task_rate  = r_task_rate;
        n_sat_size   = r_sat_size;
        n_sat_task   = r_sat_task;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        w_pop        = 1'b0;
        w_load       = 1'b0;
        w_div_start  = 1'b0;

        case (r_state)
            swrm_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_rejected = 1'b0;
                    n_state    = swrm_pkg::ST_DONE;
                    if (w_action == swrm_pkg::ACT_ADD) begin
                        if (r_count >= CNT_BITS'(FIFO_DEPTH)) begin
                            // full window, drop the task
                            n_rejected = 1'b1;
                        end else begin
                            w_load  = 1'b1;
                            n_count = r_count + 1'b1;
                            n_sum   = r_sum + SUM_BITS'(w_size);
                            if (w_adds_inc == r_power) begin
                                n_adds     = '0;
                                n_removals = '0;
                                n_state    = swrm_pkg::ST_START;
                            end else begin
                                n_adds = w_adds_inc;
                            end
                        end
                    end else if (r_count != '0) begin
                        // boundary saturates at zero
                        n_board = (w_now >= w_period_ext) ? w_now - w_period_ext : '0;
                        n_state = swrm_pkg::ST_POP;
                    end
                end
            end

            swrm_pkg::ST_POP: begin
                if (w_head_old) begin
                    w_pop      = 1'b1;
                    n_count    = r_count - 1'b1;
                    n_sum      = r_sum - SUM_BITS'(w_weight[0]);
                    n_removals = r_removals + 32'd1;
                end else begin
                    n_state = swrm_pkg::ST_DONE;
                    if (r_count == '0) begin
                        n_state = swrm_pkg::ST_START;
                    end
                    if (r_removals >= r_power) begin
                        n_removals = '0;
                        n_state    = swrm_pkg::ST_START;
                    end
                end
            end

            swrm_pkg::ST_START: begin
                w_div_start = 1'b1;
                n_sat_size  = w_zero_cfg || (w_prod_size > NUM_LIMIT);
                n_sat_task  = w_zero_cfg || (w_prod_task > NUM_LIMIT);
                n_state     = swrm_pkg::ST_DIV;
            end

            swrm_pkg::ST_DIV: begin
                if (w_done_size && w_done_task) begin
                    if (r_sat_size || (w_quo_size > DIV_BITS'(swrm_pkg::SIZE_RATE_MAX))) begin
                        n_size_rate = swrm_pkg::SIZE_RATE_MAX;
                    end else begin
                        n_size_rate = w_quo_size[SR_BITS-1:0];
                    end
                    if (r_sat_task || (w_quo_task > DIV_BITS'(swrm_pkg::TASK_RATE_MAX))) begin
                        n_task_rate = swrm_pkg::TASK_RATE_MAX;
                    end else begin
                        n_task_rate = w_quo_task[TR_BITS-1:0];
                    end
                    n_state = swrm_pkg::ST_DONE;
                end
            end

            swrm_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[SR_BITS-1:0]                       = r_size_rate;
                    n_out_data[SR_BITS+TR_BITS-1:SR_BITS]         = r_task_rate;
                    n_out_data[SR_BITS+TR_BITS+CNT_BITS-1:SR_BITS+TR_BITS] = r_count;
                    n_out_user  = r_rejected;
                    n_state     = swrm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = swrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swrm_pkg::ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_adds      <= '0;
            r_removals  <= '0;
            r_size_rate <= '0;
            r_task_rate <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_adds      <= n_adds;
            r_removals  <= n_removals;
            r_size_rate <= n_size_rate;
            r_task_rate <= n_task_rate;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_board    <= n_board;
        r_rejected <= n_rejected;
        r_sat_size <= n_sat_size;
        r_sat_task <= n_sat_task;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == swrm_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
